// ===== design/assert_macros.svh =====
// Shared assertion macros for the track encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed: same-cycle check");

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== design/fmtrk_pkg.sv =====
package fmtrk_pkg;

    localparam int POS_BITS   = 18;
    localparam int LEN_W      = 18;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int STEP_W     = 5;
    localparam int FOLD_CNT_W = $clog2(POS_BITS);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    localparam logic [LEN_W-1:0]     TRACK_LEN_RESET = LEN_W'(100000);
    localparam logic [STEP_W-1:0]    WORD_CELLS      = STEP_W'(16);
    localparam logic [CFG_IDX_W-1:0] CFG_MFM_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LEN   = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } fold_stat_t;

    // Place bit k of a byte at bit 2k of a word.
    function automatic logic [WORD_W-1:0] spread_bits(input logic [BYTE_W-1:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            r[2*k] = v[k];
        end
        return r;
    endfunction

    // Sixteen modulo a track length of 1 to 15 cells.
    function automatic logic [STEP_W-1:0] sixteen_mod(input logic [3:0] len);
        logic [STEP_W-1:0] r;
        case (len)
            4'd3:    r = STEP_W'(1);
            4'd5:    r = STEP_W'(1);
            4'd6:    r = STEP_W'(4);
            4'd7:    r = STEP_W'(2);
            4'd9:    r = STEP_W'(7);
            4'd10:   r = STEP_W'(6);
            4'd11:   r = STEP_W'(5);
            4'd12:   r = STEP_W'(4);
            4'd13:   r = STEP_W'(3);
            4'd14:   r = STEP_W'(2);
            4'd15:   r = STEP_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/fmtrk_in_if.sv =====
interface fmtrk_in_if;
    import fmtrk_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   data_byte;
    logic [BYTE_W-1:0]   clock_mask;
    logic                start_of_run;
    logic [POS_BITS-1:0] start_bit_pos;
    logic                end_of_run;

    modport source (
        output valid, data_byte, clock_mask, start_of_run, start_bit_pos, end_of_run,
        input  ready
    );

    modport sink (
        input  valid, data_byte, clock_mask, start_of_run, start_bit_pos, end_of_run,
        output ready
    );
endinterface

// ===== design/fmtrk_out_if.sv =====
interface fmtrk_out_if;
    import fmtrk_pkg::*;

    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   raw_word;
    logic [POS_BITS-1:0] bit_pos;
    logic                straddles_end;
    logic                range_error;
    logic                last_word;

    modport source (
        output valid, raw_word, bit_pos, straddles_end, range_error, last_word,
        input  ready
    );

    modport sink (
        input  valid, raw_word, bit_pos, straddles_end, range_error, last_word,
        output ready
    );
endinterface

// ===== design/fmtrk_cells.sv =====
module fmtrk_cells (
    input  logic [fmtrk_pkg::BYTE_W-1:0] data_byte,
    input  logic [fmtrk_pkg::BYTE_W-1:0] clock_mask,
    input  logic                         prev_bit,
    input  logic                         mfm_mode,
    output logic [fmtrk_pkg::WORD_W-1:0] raw_word
);
    import fmtrk_pkg::*;

    logic [BYTE_W-1:0] before_bits;
    logic [BYTE_W-1:0] clock_bits;
    logic [WORD_W-1:0] clock_cells;

    // Pair each data bit with the bit sent just before it
    assign before_bits = {prev_bit, data_byte[BYTE_W-1:1]};

    // MFM: clock only between two zeros, gated by the mask; FM: mask is the clock
    assign clock_bits = mfm_mode ? (~(data_byte | before_bits) & clock_mask) : clock_mask;

    // Interleave clock cells on odd bits, data cells on even bits
    assign clock_cells = spread_bits(clock_bits);
    assign raw_word    = spread_bits(data_byte) | {clock_cells[WORD_W-2:0], 1'b0};
endmodule

// ===== design/fmtrk_fold.sv =====
module fmtrk_fold (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fmtrk_pkg::POS_BITS-1:0] dividend,
    input  logic [fmtrk_pkg::LEN_W-1:0]    divisor,
    output logic [fmtrk_pkg::LEN_W-1:0]    remainder,
    output fmtrk_pkg::fold_stat_t          stat
);
    import fmtrk_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [FOLD_CNT_W-1:0] cnt_reg;
    logic [POS_BITS-1:0]   dvd_reg;
    logic [LEN_W-1:0]      rem_reg;
    logic [LEN_W:0]        rem_shift;
    logic [LEN_W:0]        rem_diff;
    logic [LEN_W-1:0]      rem_next;

    // One restoring remainder step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, dvd_reg[POS_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign rem_next  = (rem_shift >= {1'b0, divisor}) ? rem_diff[LEN_W-1:0]
                                                      : rem_shift[LEN_W-1:0];

    // Sequence the steps, one dividend bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == FOLD_CNT_W'(POS_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the partial remainder and the bits still to shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[POS_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

// ===== design/fm_mfm_track_encoder_core.sv =====
// Each accepted word's result word is registered in the output register.
// One word per cycle while not stalled; input ready follows output ready through
// the register. A write to the track length stalls the input while the remainder
// unit reduces the held position modulo the new length, one bit per cycle.
// Reset: MFM mode, track length 100000, position 0, previous data bit 1, output empty.
`include "assert_macros.svh"

module fm_mfm_track_encoder_core (
    input  logic                             clk,
    input  logic                             rst_n,
    fmtrk_in_if.sink                         data_in,
    fmtrk_out_if.source                      data_out,
    input  logic                             cfg_we,
    input  logic [fmtrk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fmtrk_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fmtrk_pkg::*;

    logic                mfm_mode_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                prev_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0] pos_mod_reg;
    logic                fold_start_reg;

    logic                out_valid_reg;
    logic [WORD_W-1:0]   raw_word_reg;
    logic [POS_BITS-1:0] bit_pos_reg;
    logic                straddles_reg;
    logic                range_err_reg;
    logic                last_word_reg;

    logic                accept;
    logic                fold_busy;
    fold_stat_t          fold_stat;
    logic [LEN_W-1:0]    fold_rem;
    logic                range_err;
    logic [POS_BITS-1:0] pos_cur;
    logic [POS_BITS-1:0] mod_cur;
    logic                prev_cur;
    logic [STEP_W-1:0]   step;
    logic [LEN_W:0]      step_sum;
    logic [LEN_W:0]      step_diff;
    logic [POS_BITS-1:0] pos_next;
    logic                straddles;
    logic [WORD_W-1:0]   raw_word;

    // Handshake: stall while the position is being folded or the output word is held
    assign fold_busy     = fold_start_reg | fold_stat.busy | fold_stat.done;
    assign data_in.ready = !fold_busy && (!out_valid_reg || data_out.ready);
    assign accept        = data_in.valid && data_in.ready;

    // Resolve the run start
    assign range_err = data_in.start_of_run && (data_in.start_bit_pos >= len_reg);
    assign pos_cur   = data_in.start_of_run ? (range_err ? '0 : data_in.start_bit_pos)
                                            : pos_reg;
    assign mod_cur   = data_in.start_of_run ? pos_cur : pos_mod_reg;
    assign prev_cur  = data_in.start_of_run | prev_reg;

    // Advance by sixteen cells modulo the track length
    always_comb
    begin
        if (len_reg > LEN_W'(WORD_CELLS))
            step = WORD_CELLS;
        else if (len_reg == LEN_W'(WORD_CELLS))
            step = '0;
        else
            step = sixteen_mod(len_reg[3:0]);
    end

    assign step_sum  = {1'b0, mod_cur} + (LEN_W + 1)'(step);
    assign step_diff = step_sum - {1'b0, len_reg};

    always_comb
    begin
        if (len_reg == '0)
            pos_next = '0;
        else if (step_sum >= {1'b0, len_reg})
            pos_next = step_diff[POS_BITS-1:0];
        else
            pos_next = step_sum[POS_BITS-1:0];
    end

    assign straddles = ({1'b0, pos_cur} + (POS_BITS + 1)'(WORD_CELLS)) > {1'b0, len_reg};

    fmtrk_cells u_cells (
        .data_byte  (data_in.data_byte),
        .clock_mask (data_in.clock_mask),
        .prev_bit   (prev_cur),
        .mfm_mode   (mfm_mode_reg),
        .raw_word   (raw_word)
    );

    fmtrk_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (fold_start_reg),
        .dividend  (pos_reg),
        .divisor   (len_reg),
        .remainder (fold_rem),
        .stat      (fold_stat)
    );

    // Take register writes and launch a fold after a length change
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mfm_mode_reg   <= 1'b1;
            len_reg        <= TRACK_LEN_RESET;
            fold_start_reg <= 1'b0;
        end
        else
        begin
            fold_start_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MFM_MODE:
                        mfm_mode_reg <= cfg_data[0];
                    CFG_TRACK_LEN:
                    begin
                        len_reg        <= cfg_data[LEN_W-1:0];
                        fold_start_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Advance the run state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= 1'b1;
            pos_reg     <= '0;
            pos_mod_reg <= '0;
        end
        else if (accept)
        begin
            prev_reg    <= data_in.data_byte[0];
            pos_reg     <= pos_next;
            pos_mod_reg <= pos_next;
        end
        else if (fold_stat.done)
        begin
            pos_mod_reg <= fold_rem[POS_BITS-1:0];
        end
    end

    // Hold the result word until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (data_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_word_reg  <= raw_word;
            bit_pos_reg   <= pos_cur;
            straddles_reg <= straddles;
            range_err_reg <= range_err;
            last_word_reg <= data_in.end_of_run;
        end
    end

    assign data_out.valid         = out_valid_reg;
    assign data_out.raw_word      = raw_word_reg;
    assign data_out.bit_pos       = bit_pos_reg;
    assign data_out.straddles_end = straddles_reg;
    assign data_out.range_error   = range_err_reg;
    assign data_out.last_word     = last_word_reg;

    `ASSERT_SAME(a_no_accept_in_fold, fold_busy, !data_in.ready)
    `ASSERT_SAME(a_mod_in_range, !fold_busy && (len_reg != '0), pos_mod_reg < len_reg)
    `ASSERT_NEXT(a_accept_fills_out, accept, data_out.valid)
    `ASSERT_SAME(a_range_err_at_zero, data_out.valid && data_out.range_error,
                 data_out.bit_pos == '0)
endmodule
